@@ rtl/core/msbb_pkg.sv @@
// Package for the mono bitmap stream blitter: shared types and constants.
// Used by every module of the block.
package msbb_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

  typedef struct packed {
    logic [7:0] origin_x;
    logic [7:0] origin_y;
    logic [3:0] scale;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] width;
    logic [7:0] height;
    logic       restart;
  } qent_t;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [3:0] square_side;
    logic       pixel_on;
    logic       last_of_byte;
  } cmd_t;

endpackage

@@ rtl/core/msbb_in_if.sv @@
// Input channel of the blitter: one file byte per transfer.
// Depends on nothing but the valid/ready convention.
interface msbb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

@@ rtl/core/msbb_out_if.sv @@
// Result channel of the blitter: one square-fill command per transfer.
// Depends on nothing but the valid/ready convention.
interface msbb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [3:0] square_side;
  logic       pixel_on;
  logic       last_of_byte;

  modport source (output valid, output pixel_x, output pixel_y, output square_side,
                  output pixel_on, output last_of_byte, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input square_side,
                  input pixel_on, input last_of_byte, output ready);
endinterface

@@ rtl/core/msbb_front.sv @@
// Front end: takes input bytes, consumes the two header bytes and queues
// pixel bytes together with the current image size. Uses msbb_pkg.
module msbb_front (
  input  logic            clk,
  input  logic            rst_n,
  msbb_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            q_push,
  output msbb_pkg::qent_t q_data
);
  import msbb_pkg::*;

  logic [7:0] width_r, width_nxt;
  logic [7:0] height_r, height_nxt;
  logic       hdr_left_r, hdr_left_nxt;
  logic       restart_r, restart_nxt;
  logic       accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept && !in_ch.file_start && !hdr_left_r;

  always_comb begin
    q_data.data_byte = in_ch.data_byte;
    q_data.width     = width_r;
    q_data.height    = height_r;
    q_data.restart   = restart_r;
  end

  always_comb begin
    width_nxt    = width_r;
    height_nxt   = height_r;
    hdr_left_nxt = hdr_left_r;
    restart_nxt  = restart_r;
    if (accept) begin
      if (in_ch.file_start) begin
        width_nxt    = in_ch.data_byte;
        hdr_left_nxt = 1'b1;
        restart_nxt  = 1'b1;
      end else if (hdr_left_r) begin
        height_nxt   = in_ch.data_byte;
        hdr_left_nxt = 1'b0;
      end else begin
        restart_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= '0;
      height_r   <= '0;
      hdr_left_r <= 1'b0;
      restart_r  <= 1'b0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      hdr_left_r <= hdr_left_nxt;
      restart_r  <= restart_nxt;
    end
  end

endmodule

@@ rtl/core/msbb_queue.sv @@
// Short queue of pixel bytes between the front and back ends.
// Uses msbb_pkg for the entry type and depth.
module msbb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  msbb_pkg::qent_t push_data,
  output logic            full,
  output logic            q_valid,
  input  logic            pop,
  output msbb_pkg::qent_t pop_data
);
  import msbb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qent_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_pop;

  assign full     = count_r == CNT_W'(QUEUE_DEPTH);
  assign q_valid  = count_r != '0;
  assign do_pop   = pop && q_valid;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/core/msbb_back.sv @@
// Back end: walks the eight pixels of each byte, one per cycle unless
// stalled, keeps cursors, emits square-fill commands. Uses msbb_pkg.
module msbb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  msbb_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  msbb_pkg::qent_t q_data,
  output logic            q_pop,
  msbb_out_if.source      out_ch
);
  import msbb_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [BIT_IDX_W-1:0] bit_idx_r, bit_idx_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic [7:0]           width_r, width_nxt;
  logic [7:0]           height_r, height_nxt;
  logic [7:0]           col_r, col_nxt;
  logic [7:0]           row_r, row_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  cmd_t                 pend_r, pend_nxt;
  logic                 out_vld_r, out_vld_nxt;
  cmd_t                 out_r, out_nxt;

  logic                 out_free;
  logic                 last_bit;
  logic                 gen;
  logic                 step;
  logic                 move;
  logic [7:0]           col_inc;
  logic [11:0]          prod_x;
  logic [11:0]          prod_y;
  cmd_t                 new_cmd;

  assign out_free = !out_vld_r || out_ch.ready;
  assign last_bit = bit_idx_r == BIT_IDX_W'(BITS_PER_BYTE - 1);
  assign gen      = busy_r && (row_r < height_r) && (cfg.scale != '0);
  assign step     = busy_r && (!gen || !pend_vld_r || out_free);
  assign move     = out_free && pend_vld_r && (pend_r.last_of_byte || (step && gen));
  assign q_pop    = q_valid && (!busy_r || (step && last_bit));
  assign col_inc  = col_r + 8'd1;
  assign prod_x   = 12'(col_r) * 12'(cfg.scale);
  assign prod_y   = 12'(row_r) * 12'(cfg.scale);

  always_comb begin
    new_cmd.pixel_x      = cfg.origin_x + prod_x[7:0];
    new_cmd.pixel_y      = cfg.origin_y + prod_y[7:0];
    new_cmd.square_side  = cfg.scale;
    new_cmd.pixel_on     = byte_r[BIT_IDX_W'(BITS_PER_BYTE - 1) - bit_idx_r];
    new_cmd.last_of_byte = last_bit;
  end

  always_comb begin
    busy_nxt     = busy_r;
    bit_idx_nxt  = bit_idx_r;
    byte_nxt     = byte_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;

    if (move) begin
      out_nxt     = pend_r;
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    if (step && gen) begin
      pend_nxt     = new_cmd;
      pend_vld_nxt = 1'b1;
    end else if (move) begin
      pend_vld_nxt = 1'b0;
    end else if (step && last_bit && pend_vld_r) begin
      pend_nxt.last_of_byte = 1'b1;
    end

    if (step) begin
      bit_idx_nxt = bit_idx_r + BIT_IDX_W'(1);
      if (last_bit) begin
        busy_nxt = 1'b0;
      end
      if (col_inc >= width_r) begin
        col_nxt = '0;
        row_nxt = row_r + 8'd1;
      end else begin
        col_nxt = col_inc;
      end
    end

    if (q_pop) begin
      busy_nxt    = 1'b1;
      bit_idx_nxt = '0;
      byte_nxt    = q_data.data_byte;
      width_nxt   = q_data.width;
      height_nxt  = q_data.height;
      if (q_data.restart) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    width_r  <= width_nxt;
    height_r <= height_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      bit_idx_r  <= '0;
      col_r      <= '0;
      row_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      bit_idx_r  <= bit_idx_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.pixel_x      = out_r.pixel_x;
  assign out_ch.pixel_y      = out_r.pixel_y;
  assign out_ch.square_side  = out_r.square_side;
  assign out_ch.pixel_on     = out_r.pixel_on;
  assign out_ch.last_of_byte = out_r.last_of_byte;

`ifndef ASSERT_OFF
  a_pend_open_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_vld_r && !pend_r.last_of_byte) |-> busy_r)
    else $error("open pending command without a byte in progress");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && width_r != '0) |-> (col_r < width_r))
    else $error("column cursor outside the image width");

  a_pop_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!busy_r || (step && last_bit)))
    else $error("byte loaded while the previous one is unfinished");
`endif

endmodule

@@ rtl/core/mono_bitmap_stream_blitter_top.sv @@
// Top level of the mono bitmap stream blitter: configuration registers and
// the front end, queue and back end. Uses msbb_pkg and the channel interfaces.
//
// The in_ch channel takes one file byte per transfer; a byte flagged with
// file_start begins a file and carries the image width, the next byte the
// height, and later bytes eight packed pixels each, most significant first.
// The out_ch channel delivers one square-fill command per transfer, with
// last_of_byte set on the final command caused by a pixel byte.
// Header bytes are absorbed in the front end. The back end walks a pixel
// byte pixel by pixel; a two-entry queue lets the front end keep taking
// bytes meanwhile. A byte passes through the queue, the back end's byte
// register and the pending and output command registers before its first
// command is valid on out_ch. A command waits in the pending register until
// the next command or the end of its byte decides last_of_byte. When out_ch
// stalls, the back end holds, the queue fills and in_ch.ready drops. Reset
// clears cursors, the front end's image size and header state and sets the
// scale to one. Registers on the cfg port (origin_x, origin_y, scale) are
// to be written by the user only while the block is idle; the block itself
// does not enforce this.
module mono_bitmap_stream_blitter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  msbb_in_if.sink                        in_ch,
  msbb_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [msbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [msbb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import msbb_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  q_push;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  qent_t q_in;
  qent_t q_out;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: cfg_nxt.origin_x = cfg_wdata;
        CFG_ORIGIN_Y: cfg_nxt.origin_y = cfg_wdata;
        CFG_SCALE:    cfg_nxt.scale    = cfg_wdata[3:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.scale    <= 4'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  msbb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  msbb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .q_valid   (q_valid),
    .pop       (q_pop),
    .pop_data  (q_out)
  );

  msbb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
